### rtl/rlc_pkg.sv
// Package for the refcounted LRU size-budget cache core.
// Types, kind codes, widths and the FSM state enum; no dependencies.
package rlc_pkg;

    localparam int DefEntries = 16;
    localparam int KeyW       = 32;
    localparam int SizeW      = 24;
    localparam int TotalW     = 29;
    localparam int RefW       = 8;
    localparam int SlotW      = 4;
    localparam int KindW      = 3;

    localparam logic [1:0] CMD_LOOKUP  = 2'd0;
    localparam logic [1:0] CMD_INSERT  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;   // unused code, dropped on input

    localparam logic [KindW-1:0] KIND_HIT      = 3'd0;
    localparam logic [KindW-1:0] KIND_INSERTED = 3'd1;
    localparam logic [KindW-1:0] KIND_MISS     = 3'd2;
    localparam logic [KindW-1:0] KIND_LOADFAIL = 3'd3;
    localparam logic [KindW-1:0] KIND_FULL     = 3'd4;
    localparam logic [KindW-1:0] KIND_RELEASED = 3'd5;
    localparam logic [KindW-1:0] KIND_RELERR   = 3'd6;
    localparam logic [KindW-1:0] KIND_EVICTED  = 3'd7;

    // per-cell operation, broadcast from the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PIN,      // target: refs+1, leave LRU if refs was 0
        OP_UNREF,    // target: refs-1, join LRU tail on zero
        OP_INSERT,   // target: load new entry
        OP_EVICT     // entry at LRU rank 0 is dropped
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [KeyW-1:0]  key;
        logic [SizeW-1:0] size;
        logic [8:0]       rank;     // removed rank or new tail rank
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EVICT,
        ST_OUT
    } state_t;

endpackage

### rtl/rlc_cell.sv
// One slot of the cache: valid, key, size, refcount and LRU rank.
// Depends on rlc_pkg; driven by the controller's broadcast control.
module rlc_cell #(
    parameter int RankW = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sel,
    input  rlc_pkg::cell_ctl_t       ctl,
    output logic                     valid,
    output logic                     hit,
    output logic [rlc_pkg::KeyW-1:0] key,
    output logic [rlc_pkg::SizeW-1:0] size,
    output logic [rlc_pkg::RefW-1:0] refs,
    output logic [RankW-1:0]         rank,
    output logic                     oldest
);
    import rlc_pkg::*;

    logic              valid_reg, valid_next;
    logic [KeyW-1:0]   key_reg, key_next;
    logic [SizeW-1:0]  size_reg, size_next;
    logic [RefW-1:0]   refs_reg, refs_next;
    logic [RankW-1:0]  rank_reg, rank_next;
    logic              in_lru;
    logic [RankW-1:0]  crank;

    assign crank  = ctl.rank[RankW-1:0];
    assign in_lru = valid_reg && (refs_reg == '0);
    assign valid  = valid_reg;
    assign hit    = valid_reg && (key_reg == ctl.key);
    assign key    = key_reg;
    assign size   = size_reg;
    assign refs   = refs_reg;
    assign rank   = rank_reg;
    assign oldest = in_lru && (rank_reg == '0);

    // update of the cell
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        size_next  = size_reg;
        refs_next  = refs_reg;
        rank_next  = rank_reg;
        case (ctl.op)
            OP_PIN:
            begin
                if (sel)
                    refs_next = refs_reg + 1'b1;
                else if (in_lru && rank_reg > crank)
                    rank_next = rank_reg - 1'b1;
            end
            OP_UNREF:
            begin
                if (sel)
                begin
                    refs_next = refs_reg - 1'b1;
                    if (refs_reg == 8'd1)
                        rank_next = crank;
                end
            end
            OP_INSERT:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    key_next   = ctl.key;
                    size_next  = ctl.size;
                    refs_next  = 8'd1;
                    rank_next  = '0;
                end
            end
            OP_EVICT:
            begin
                if (oldest)
                    valid_next = 1'b0;
                else if (in_lru)
                    rank_next = rank_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        size_reg <= size_next;
        refs_reg <= refs_next;
        rank_reg <= rank_next;
    end

endmodule

### rtl/refcounted_lru_size_budget_cache_core.sv
// Top level of the refcounted LRU size-budget cache: controller and row of cells.
// Depends on rlc_pkg and rlc_cell.
// An input beat is registered and decided; its first result beat is then offered in ST_OUT.
// Items are taken one at a time: decide and output steps, plus an evict and an output
// step per eviction, walking the LRU order one victim per pass; ST_OUT waits on m_tready.
// Reset: asynchronous, active low; table empty, LRU empty, total and budget zero.
module refcounted_lru_size_budget_cache_core #(
    parameter int ENTRIES = rlc_pkg::DefEntries
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // cmd[1:0] key[33:2] loaded_size[57:34] load_ok[58]
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [39:0] m_tdata,    // kind[2:0] slot[6:3] entry_key[38:7]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import rlc_pkg::*;

    localparam int IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RankW = $clog2(ENTRIES + 1);

    logic [31:0]        budget_reg;
    state_t             state_reg, state_next;
    logic [1:0]         cmd_reg;
    logic [KeyW-1:0]    key_reg;
    logic [SizeW-1:0]   lsize_reg;
    logic               ok_reg;
    logic [RankW-1:0]   lru_len_reg, lru_len_next;
    logic [TotalW-1:0]  total_reg, total_next;
    logic [KindW-1:0]   okind_reg, okind_next;
    logic [IdxW-1:0]    oslot_reg, oslot_next;
    logic [KeyW-1:0]    okey_reg, okey_next;
    logic               olast_reg, olast_next;

    cell_ctl_t          ctl;
    logic [ENTRIES-1:0] c_valid, c_hit, c_oldest, c_sel;
    logic [KeyW-1:0]    c_key  [ENTRIES];
    logic [SizeW-1:0]   c_size [ENTRIES];
    logic [RefW-1:0]    c_refs [ENTRIES];
    logic [RankW-1:0]   c_rank [ENTRIES];

    // hit / free / victim search, lowest index wins
    logic               found, free_any, vic_any;
    logic [IdxW-1:0]    hit_idx, free_idx, vic_idx;
    always_comb
    begin
        found = 1'b0; hit_idx = '0;
        free_any = 1'b0; free_idx = '0;
        vic_any = 1'b0; vic_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (c_hit[i])
            begin
                found = 1'b1;
                hit_idx = IdxW'(i);
            end
            if (!c_valid[i])
            begin
                free_any = 1'b1;
                free_idx = IdxW'(i);
            end
            if (c_oldest[i])
            begin
                vic_any = 1'b1;
                vic_idx = IdxW'(i);
            end
        end
    end

    logic [RefW-1:0]  hrefs;
    logic [RankW-1:0] hrank;
    logic [SizeW-1:0] vsize;
    logic [KeyW-1:0]  vkey;
    assign hrefs = c_refs[hit_idx];
    assign hrank = c_rank[hit_idx];
    assign vsize = c_size[vic_idx];
    assign vkey  = c_key[vic_idx];

    // cell row
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        rlc_cell #(.RankW(RankW)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .sel    (c_sel[g]),
            .ctl    (ctl),
            .valid  (c_valid[g]),
            .hit    (c_hit[g]),
            .key    (c_key[g]),
            .size   (c_size[g]),
            .refs   (c_refs[g]),
            .rank   (c_rank[g]),
            .oldest (c_oldest[g])
        );
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {1'b0, okey_reg, SlotW'(oslot_reg), okind_reg};
    assign m_tlast  = olast_reg;

    logic over;
    assign over = ({3'b0, total_next} > budget_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid && s_tdata[1:0] != CMD_NONE) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_EVICT:  state_next = ST_OUT;
            ST_OUT:
                if (m_tready)
                    state_next = olast_reg ? ST_IDLE : ST_EVICT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and cell control
    always_comb
    begin
        ctl.op   = OP_NONE;
        ctl.key  = key_reg;
        ctl.size = lsize_reg;
        ctl.rank = '0;
        c_sel    = '0;
        lru_len_next = lru_len_reg;
        total_next   = total_reg;
        okind_next   = okind_reg;
        oslot_next   = oslot_reg;
        okey_next    = okey_reg;
        olast_next   = olast_reg;
        case (state_reg)
            ST_DECIDE:
            begin
                okey_next  = key_reg;
                oslot_next = '0;
                olast_next = 1'b1;
                if (cmd_reg == CMD_RELEASE)
                begin
                    okind_next = KIND_RELERR;
                    if (found)
                    begin
                        oslot_next = hit_idx;
                        if (hrefs != '0)
                        begin
                            okind_next = KIND_RELEASED;
                            ctl.op = OP_UNREF;
                            ctl.rank = 9'(lru_len_reg);
                            c_sel[hit_idx] = 1'b1;
                            if (hrefs == 8'd1)
                                lru_len_next = lru_len_reg + 1'b1;
                        end
                    end
                end
                else if (found)
                begin
                    oslot_next = hit_idx;
                    if (hrefs == 8'hFF)
                        okind_next = KIND_FULL;
                    else
                    begin
                        okind_next = KIND_HIT;
                        ctl.op = OP_PIN;
                        // closing the gap behind the hit's own rank; all-ones touches nobody
                        ctl.rank = (hrefs == '0) ? 9'(hrank) : 9'h1FF;
                        c_sel[hit_idx] = 1'b1;
                        if (hrefs == '0)
                            lru_len_next = lru_len_reg - 1'b1;
                    end
                end
                else if (cmd_reg == CMD_LOOKUP)
                    okind_next = KIND_MISS;
                else if (!ok_reg)
                    okind_next = KIND_LOADFAIL;
                else if (!free_any)
                    okind_next = KIND_FULL;
                else
                begin
                    okind_next = KIND_INSERTED;
                    oslot_next = free_idx;
                    ctl.op = OP_INSERT;
                    c_sel[free_idx] = 1'b1;
                    total_next = total_reg + TotalW'(lsize_reg);
                    olast_next = !(over && lru_len_reg != '0);
                end
            end
            ST_EVICT:
            begin
                ctl.op = OP_EVICT;
                lru_len_next = lru_len_reg - 1'b1;
                total_next = total_reg - TotalW'(vsize);
                okind_next = KIND_EVICTED;
                oslot_next = vic_idx;
                okey_next  = vkey;
                olast_next = !(over && lru_len_next != '0);
            end
            default:
            begin
            end
        endcase
    end

    // control state, LRU length, size total and budget
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            budget_reg  <= '0;
            lru_len_reg <= '0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            lru_len_reg <= lru_len_next;
            total_reg   <= total_next;
            if (cfg_we)
                budget_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg   <= s_tdata[1:0];
            key_reg   <= s_tdata[33:2];
            lsize_reg <= s_tdata[57:34];
            ok_reg    <= s_tdata[58];
        end
        okind_reg <= okind_next;
        oslot_reg <= oslot_next;
        okey_reg  <= okey_next;
        olast_reg <= olast_next;
    end

endmodule
